>>> hdl/sdchd_pkg.sv
// ----------------------------------------------------------------------------
// sdchd_pkg
// Shared types and constants for the button gesture detector: register
// indexes, reset values, gesture codes and the configuration bundle.
// ----------------------------------------------------------------------------
package sdchd_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned NOW_MS_W       = 32;
  localparam int unsigned LIMIT_W        = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = LIMIT_W;
  localparam int unsigned GESTURE_W      = 2;
  localparam int unsigned CLICK_CNT_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LEVEL   = 3'd0,
    CFG_CLICK_MAX_MS   = 3'd1,
    CFG_LONG_MIN_MS    = 3'd2,
    CFG_REPEAT_MS      = 3'd3,
    CFG_DOUBLE_WAIT_MS = 3'd4
  } cfg_idx_e;

  typedef enum logic [GESTURE_W-1:0] {
    GESTURE_NONE   = 2'd0,
    GESTURE_SINGLE = 2'd1,
    GESTURE_DOUBLE = 2'd2
  } gesture_e;

  localparam logic [CLICK_CNT_W-1:0] CLICKS_NONE = 2'd0;
  localparam logic [CLICK_CNT_W-1:0] CLICKS_ONE  = 2'd1;
  localparam logic [CLICK_CNT_W-1:0] CLICKS_TWO  = 2'd2;

  localparam logic               ACTIVE_LEVEL_RST   = 1'b0;
  localparam logic [LIMIT_W-1:0] CLICK_MAX_MS_RST   = 16'd500;
  localparam logic [LIMIT_W-1:0] LONG_MIN_MS_RST    = 16'd1000;
  localparam logic [LIMIT_W-1:0] REPEAT_MS_RST      = 16'd200;
  localparam logic [LIMIT_W-1:0] DOUBLE_WAIT_MS_RST = 16'd300;

  typedef struct packed {
    logic               active_level;
    logic [LIMIT_W-1:0] click_max_ms;
    logic [LIMIT_W-1:0] long_min_ms;
    logic [LIMIT_W-1:0] repeat_ms;
    logic [LIMIT_W-1:0] double_wait_ms;
  } cfg_t;

endpackage

>>> hdl/sdchd_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdchd_cfg_regs
// Write-only configuration registers of the gesture detector, bundled into
// one struct for the classification logic.
// ----------------------------------------------------------------------------
module sdchd_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdchd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sdchd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output sdchd_pkg::cfg_t                    cfg_o
);
  import sdchd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_LEVEL:   cfg_d.active_level   = cfg_data_i[0];
        CFG_CLICK_MAX_MS:   cfg_d.click_max_ms   = cfg_data_i;
        CFG_LONG_MIN_MS:    cfg_d.long_min_ms    = cfg_data_i;
        CFG_REPEAT_MS:      cfg_d.repeat_ms      = cfg_data_i;
        CFG_DOUBLE_WAIT_MS: cfg_d.double_wait_ms = cfg_data_i;
        default:            cfg_d = cfg_q; // ignore unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level   <= ACTIVE_LEVEL_RST;
      cfg_q.click_max_ms   <= CLICK_MAX_MS_RST;
      cfg_q.long_min_ms    <= LONG_MIN_MS_RST;
      cfg_q.repeat_ms      <= REPEAT_MS_RST;
      cfg_q.double_wait_ms <= DOUBLE_WAIT_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/single_double_click_hold_detector_unit.sv
// ----------------------------------------------------------------------------
// single_double_click_hold_detector_unit
// Classifies button polls into click, double click and long-press repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one request per poll, carrying
//   the sampled pin level and a free-running millisecond timestamp. Time
//   differences wrap modulo 2^TIME_WIDTH.
//   Output channel (out_valid_o / out_stall_i): exactly one result per
//   request: gesture (0 none, 1 click or hold repeat, 2 double click) and
//   hold_active.
//   An accepted request sits in the input register; the classification step
//   then writes the gesture state and the result register together.
//   Throughput is one request per cycle while the receiver does not stall;
//   the state update is a single pass of wrap-around subtracts and compares,
//   so back-to-back requests chain.
//   When the receiver stalls, the result register holds, the request in the
//   input register waits, and in_stall_o rises once both are occupied.
//   Reset clears all gesture state and loads the default limits.
//   Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module single_double_click_hold_detector_unit #(
  parameter int unsigned TIME_WIDTH = sdchd_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sdchd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sdchd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 pin_level_i,
  input  logic [sdchd_pkg::NOW_MS_W-1:0]       now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sdchd_pkg::GESTURE_W-1:0]      gesture_o,
  output logic                                 hold_active_o
);
  import sdchd_pkg::*;

  cfg_t cfg;

  sdchd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register
  logic                  in_valid_q;
  logic                  pin_level_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  in_accept;
  logic                  advance;

  // Result register
  logic                 out_valid_q;
  logic [GESTURE_W-1:0] gesture_q, gesture_d;
  logic                 hold_active_q;

  // Gesture state
  logic                   armed_q, armed_d;
  logic                   hold_q, hold_d;
  logic [CLICK_CNT_W-1:0] click_cnt_q, click_cnt_d;
  logic [TIME_WIDTH-1:0]  press_start_q, press_start_d;
  logic [TIME_WIDTH-1:0]  first_click_q, first_click_d;
  logic [TIME_WIDTH-1:0]  last_repeat_q, last_repeat_d;

  logic                  pressed;
  logic [TIME_WIDTH-1:0] press_elapsed;
  logic [TIME_WIDTH-1:0] click_elapsed;
  logic [TIME_WIDTH-1:0] repeat_elapsed;
  logic [TIME_WIDTH-1:0] click_max_t;
  logic [TIME_WIDTH-1:0] long_min_t;
  logic [TIME_WIDTH-1:0] repeat_t;
  logic [TIME_WIDTH-1:0] double_wait_t;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pin_level_q <= pin_level_i;
      now_q       <= TIME_WIDTH'(now_ms_i);
    end
  end

  assign pressed       = (pin_level_q == cfg.active_level);
  assign click_max_t   = TIME_WIDTH'(cfg.click_max_ms);
  assign long_min_t    = TIME_WIDTH'(cfg.long_min_ms);
  assign repeat_t      = TIME_WIDTH'(cfg.repeat_ms);
  assign double_wait_t = TIME_WIDTH'(cfg.double_wait_ms);

  // Start time is taken from this poll when the press begins now.
  assign press_start_d  = (!hold_q && !armed_q && pressed) ? now_q : press_start_q;
  assign press_elapsed  = now_q - press_start_d;
  assign first_click_d  = (!hold_q && armed_q | pressed) && !pressed &&
                          (press_elapsed <= click_max_t) && (click_cnt_q == CLICKS_NONE)
                          ? now_q : first_click_q;
  assign click_elapsed  = now_q - first_click_d;
  assign repeat_elapsed = now_q - last_repeat_q;

  always_comb begin
    logic armed_n;
    logic dropped;
    armed_n       = armed_q;
    dropped       = 1'b0;
    armed_d       = armed_q;
    hold_d        = hold_q;
    click_cnt_d   = click_cnt_q;
    last_repeat_d = last_repeat_q;
    gesture_d     = GESTURE_NONE;
    if (!hold_q) begin
      if (!armed_q && pressed) begin
        armed_n = 1'b1;
      end
      armed_d = armed_n;
      if (armed_n) begin
        if (!pressed) begin
          armed_d = 1'b0;
          if (press_elapsed <= click_max_t) begin
            click_cnt_d = click_cnt_q + CLICKS_ONE;
          end else begin
            // slow release: drop the press, skip the pending click check
            dropped = 1'b1;
          end
        end else if (press_elapsed >= long_min_t) begin
          hold_d = 1'b1;
        end
      end
      if (!dropped) begin
        if (click_cnt_d == CLICKS_ONE && click_elapsed >= double_wait_t) begin
          click_cnt_d = CLICKS_NONE;
          armed_d     = 1'b0;
          gesture_d   = GESTURE_SINGLE;
        end else if (click_cnt_d == CLICKS_TWO) begin
          click_cnt_d = CLICKS_NONE;
          armed_d     = 1'b0;
          gesture_d   = GESTURE_DOUBLE;
        end
      end
    end else if (pressed) begin
      if (repeat_elapsed >= repeat_t) begin
        last_repeat_d = now_q;
        gesture_d     = GESTURE_SINGLE;
      end
    end else begin
      hold_d  = 1'b0;
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q       <= 1'b0;
      hold_q        <= 1'b0;
      click_cnt_q   <= CLICKS_NONE;
      press_start_q <= '0;
      first_click_q <= '0;
      last_repeat_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        armed_q       <= armed_d;
        hold_q        <= hold_d;
        click_cnt_q   <= click_cnt_d;
        press_start_q <= press_start_d;
        first_click_q <= first_click_d;
        last_repeat_q <= last_repeat_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gesture_q     <= gesture_d;
      hold_active_q <= hold_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gesture_o     = gesture_q;
  assign hold_active_o = hold_active_q;

`ifndef ASSERT_OFF
  a_click_cnt_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    click_cnt_q != CLICKS_TWO)
    else $error("click count left at two after a poll");

  a_result_holds_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=>
      out_valid_q && $stable(gesture_q) && $stable(hold_active_q))
    else $error("result changed while stalled");

  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(hold_q) && $stable(armed_q) && $stable(click_cnt_q))
    else $error("gesture state changed without a request");

  a_no_double_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hold_active_q |-> gesture_q != GESTURE_DOUBLE)
    else $error("double click reported while holding");
`endif

endmodule
